@@ rtl/pbs_pkg.sv @@
package pbs_pkg;

  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 10;
  localparam int CODE_W  = 5;
  localparam int DIV_CNT_W = $clog2(TIME_W);

  localparam logic [7:0] LETTER_A = 8'h61;
  localparam logic [7:0] LETTER_Z = 8'h7a;
  localparam logic [7:0] LETTER_END = 8'h00;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 10'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_STEP = 10'd22;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SLOT = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_BUFFERED = 2'd3
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_COPY_RD = 10'b00_0000_0010,
    S_COPY_WR = 10'b00_0000_0100,
    S_SCAN    = 10'b00_0000_1000,
    S_LEN     = 10'b00_0001_0000,
    S_DIV     = 10'b00_0010_0000,
    S_FETCH   = 10'b00_0100_0000,
    S_LEVEL   = 10'b00_1000_0000,
    S_READ    = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  // Map a raw byte onto a letter code 0..25, saturating at both ends.
  function automatic logic [CODE_W-1:0] letter_code(input logic [7:0] raw);
    logic [7:0] diff;
    diff = raw - LETTER_A;
    if (raw < LETTER_A) begin
      letter_code = '0;
    end else if (raw > LETTER_Z) begin
      letter_code = CODE_W'(25);
    end else begin
      letter_code = diff[CODE_W-1:0];
    end
  endfunction

endpackage

@@ rtl/pbs_ram.sv @@
module pbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pattern_brightness_sequencer_core.sv @@
// Brightness pattern sequencer.
//
// Slave channel (s_*): one item per handshake. s_tuser carries the operation
// (write letter, time tick, read level); s_tdata carries slot index, letter
// byte and time. Letters are buffered one per write item; a write with a
// zero letter commits the buffered pattern to the addressed slot.
// Master channel (m_*): exactly one result item per accepted item, status in
// m_tuser and level in m_tdata.
//
// Work per item after accept: a letter write goes straight to the result, a
// commit makes one staging RAM read and one pattern RAM write per letter, a
// read makes one level RAM read; a tick walks all slots, writes full level for
// a present empty slot and, for one with letters, runs the shared 1-bit-per-
// cycle remainder unit over the 32 time bits (time modulo length). One item
// is in work at a time; s_tready is high only while the sequencer is idle.
//
// The result sits in an output register, so the next item is accepted while
// it waits; a stalled receiver only holds the block once a second result is
// ready. Reset idles the sequencer and clears the slot-present and level-valid
// bits, the staging count and m_tvalid; pattern memories need no clearing.
module pattern_brightness_sequencer_core
  import pbs_pkg::*;
#(
  parameter int NUM_STYLES       = 64,
  parameter int PATTERN_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // style_index[7:0], pattern_char[15:8], time_tenths[47:16]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // level[9:0], zero fill [15:10]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int SW  = (NUM_STYLES > 1) ? $clog2(NUM_STYLES) : 1;
  localparam int LW  = $clog2(PATTERN_CAPACITY);
  localparam int CW  = $clog2(PATTERN_CAPACITY + 1);
  localparam int SAW = $clog2(NUM_STYLES * PATTERN_CAPACITY);

  // Input field split.
  logic [7:0]        in_idx;
  logic [7:0]        in_char;
  logic [TIME_W-1:0] in_time;
  op_t               in_op;
  logic              accept;
  logic              idx_bad;

  assign in_idx  = s_tdata[7:0];
  assign in_char = s_tdata[15:8];
  assign in_time = s_tdata[47:16];
  assign in_op   = op_t'(s_tuser);
  assign accept  = s_tvalid && s_tready;
  assign idx_bad = {1'b0, in_idx} >= 9'(NUM_STYLES);

  // Control state.
  state_t                state;
  logic [CW-1:0]         stage_cnt;
  logic [NUM_STYLES-1:0] present;
  logic [NUM_STYLES-1:0] lvl_valid;

  // Working registers.
  logic [SW-1:0]          slot;
  logic [LW-1:0]          copy_idx;
  logic [LW-1:0]          copy_len;
  logic [TIME_W-1:0]      dvd;
  logic [LW-1:0]          rem;
  logic [DIV_CNT_W-1:0]   div_cnt;
  status_t                res_status;
  logic [LEVEL_W-1:0]     res_level;
  logic [TIME_W-1:0]      in_time_hold;

  // RAM ports.
  logic                 stg_we;
  logic [LW-1:0]        stg_raddr;
  logic [CODE_W-1:0]    stg_rdata;
  logic                 pat_we;
  logic [SAW-1:0]       pat_waddr;
  logic [SAW-1:0]       pat_raddr;
  logic [CODE_W-1:0]    pat_rdata;
  logic                 len_we;
  logic [LW-1:0]        len_rdata;
  logic                 lvl_we;
  logic [LEVEL_W-1:0]   lvl_wdata;
  logic [LEVEL_W-1:0]   lvl_rdata;
  logic [SAW-1:0]       slot_base;

  // Shared remainder step: shift in one dividend bit, subtract if it fits.
  logic [LW:0] trial;
  logic        trial_ge;
  logic [LW:0] trial_sub;

  assign trial     = {rem, dvd[TIME_W-1]};
  assign trial_ge  = trial >= {1'b0, len_rdata};
  assign trial_sub = trial - {1'b0, len_rdata};

  logic last_slot;
  logic out_free;
  logic [LEVEL_W-1:0] scaled;

  assign last_slot = slot == SW'(NUM_STYLES - 1);
  assign out_free  = !m_tvalid || m_tready;
  assign slot_base = SAW'(slot) * SAW'(PATTERN_CAPACITY);
  assign scaled    = LEVEL_W'(pat_rdata) * LEVEL_STEP;

  assign s_tready = state == S_IDLE;

  // Buffer a letter while fewer than PATTERN_CAPACITY - 1 letters are held.
  assign stg_we = accept && in_op == OP_WRITE && in_char != LETTER_END
                  && stage_cnt < CW'(PATTERN_CAPACITY - 1);
  assign stg_raddr = copy_idx;

  // Commit: length written on accept, letters copied afterwards.
  assign len_we = accept && in_op == OP_WRITE && in_char == LETTER_END && !idx_bad
                  && stage_cnt < CW'(PATTERN_CAPACITY);

  assign pat_we    = state == S_COPY_WR;
  assign pat_waddr = slot_base + SAW'(copy_idx);
  assign pat_raddr = slot_base + SAW'(rem);

  assign lvl_we    = (state == S_LEN && len_rdata == '0) || state == S_LEVEL;
  assign lvl_wdata = (state == S_LEVEL) ? scaled : LEVEL_FULL;

  pbs_ram #(.WIDTH(CODE_W), .DEPTH(PATTERN_CAPACITY)) u_stage_ram (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stage_cnt[LW-1:0]),
    .wdata (letter_code(in_char)),
    .raddr (stg_raddr),
    .rdata (stg_rdata)
  );

  pbs_ram #(.WIDTH(CODE_W), .DEPTH(NUM_STYLES * PATTERN_CAPACITY)) u_pattern_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (stg_rdata),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  pbs_ram #(.WIDTH(LW), .DEPTH(NUM_STYLES)) u_length_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (in_idx[SW-1:0]),
    .wdata (stage_cnt[LW-1:0]),
    .raddr (slot),
    .rdata (len_rdata)
  );

  pbs_ram #(.WIDTH(LEVEL_W), .DEPTH(NUM_STYLES)) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (slot),
    .wdata (lvl_wdata),
    .raddr (in_idx[SW-1:0]),
    .rdata (lvl_rdata)
  );

  // Sequencer and control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stage_cnt <= '0;
      present   <= '0;
      lvl_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads in this cycle.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_op)
              OP_WRITE: begin
                if (in_char == LETTER_END) begin
                  stage_cnt <= '0;
                  if (len_we) begin
                    present[in_idx[SW-1:0]] <= 1'b1;
                  end
                  // Copy letters only for a committed pattern that has some.
                  state <= (len_we && stage_cnt != '0) ? S_COPY_RD : S_DONE;
                end else begin
                  state <= S_DONE;
                  if (stg_we) begin
                    stage_cnt <= stage_cnt + 1'b1;
                  end else begin
                    // Past the longest pattern: park at the overflow mark.
                    stage_cnt <= CW'(PATTERN_CAPACITY);
                  end
                end
              end
              OP_TICK: state <= S_SCAN;
              OP_READ: state <= idx_bad ? S_DONE : S_READ;
              default: state <= S_DONE;
            endcase
          end
        end
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          state <= (copy_idx + 1'b1 == copy_len) ? S_DONE : S_COPY_RD;
        end
        S_SCAN: begin
          if (present[slot]) begin
            state <= S_LEN;
          end else if (last_slot) begin
            state <= S_DONE;
          end
        end
        S_LEN: begin
          if (len_rdata != '0) begin
            state <= S_DIV;
          end else begin
            state <= last_slot ? S_DONE : S_SCAN;
          end
        end
        S_DIV: begin
          if (div_cnt == DIV_CNT_W'(TIME_W - 1)) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_LEVEL;
        S_LEVEL: state <= last_slot ? S_DONE : S_SCAN;
        S_READ:  state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (lvl_we) begin
        lvl_valid[slot] <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          slot     <= (in_op == OP_TICK) ? '0 : in_idx[SW-1:0];
          copy_idx <= '0;
          copy_len <= stage_cnt[LW-1:0];
          case (in_op)
            OP_WRITE: begin
              res_level <= '0;
              if (in_char != LETTER_END) begin
                res_status <= ST_BUFFERED;
              end else if (idx_bad) begin
                res_status <= ST_BAD_SLOT;
              end else if (!len_we) begin
                res_status <= ST_TOO_LONG;
              end else begin
                res_status <= ST_OK;
              end
            end
            OP_READ: begin
              if (idx_bad) begin
                res_status <= ST_BAD_SLOT;
                res_level  <= LEVEL_FULL;
              end else begin
                res_status <= ST_OK;
                res_level  <= '0;
              end
            end
            default: begin
              res_status <= ST_OK;
              res_level  <= '0;
            end
          endcase
        end
      end
      S_COPY_WR: copy_idx <= copy_idx + 1'b1;
      S_SCAN: begin
        rem     <= '0;
        div_cnt <= '0;
        if (!present[slot] && !last_slot) begin
          slot <= slot + 1'b1;
        end
      end
      S_LEN: begin
        if (len_rdata == '0 && !last_slot) begin
          slot <= slot + 1'b1;
        end
      end
      S_DIV: begin
        rem     <= trial_ge ? trial_sub[LW-1:0] : trial[LW-1:0];
        dvd     <= {dvd[TIME_W-2:0], 1'b0};
        div_cnt <= div_cnt + 1'b1;
      end
      S_LEVEL: begin
        if (!last_slot) begin
          slot <= slot + 1'b1;
        end
      end
      S_READ: res_level <= lvl_valid[slot] ? lvl_rdata : '0;
      S_DONE: begin
        if (out_free) begin
          m_tdata <= {6'd0, res_level};
          m_tuser <= res_status;
        end
      end
      default: ;
    endcase
    // Restart the dividend for every slot of a tick.
    if (state == S_IDLE && accept) begin
      dvd <= in_time;
    end else if (state == S_LEVEL || (state == S_LEN && len_rdata == '0)) begin
      dvd <= in_time_hold;
    end
  end

  // Tick time held for the whole slot walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_time_hold <= in_time;
    end
  end

endmodule
